// ----- rtl/core/ssg_pkg.sv -----
// Package with the types and constants of the stepper step generator.
`timescale 1ns / 1ps
package ssg_pkg;

    // Input operation codes.
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_MOVE  = 3'd1;
    localparam logic [2:0] OP_RAMP  = 3'd2;
    localparam logic [2:0] OP_CONT  = 3'd3;
    localparam logic [2:0] OP_STOP  = 3'd4;
    localparam logic [2:0] OP_ENA   = 3'd5;
    localparam logic [2:0] OP_DIS   = 3'd6;

    // Configuration register indexes.
    localparam logic [1:0] REG_SPR    = 2'd0;
    localparam logic [1:0] REG_USTEP  = 2'd1;
    localparam logic [1:0] REG_TICK   = 2'd2;
    localparam logic [1:0] REG_INVERT = 2'd3;

    localparam logic [15:0] SPR_DEFAULT  = 16'd200;
    localparam logic [4:0]  USTEP_DEFAULT = 5'd16;
    localparam logic [23:0] TICK_DEFAULT = 24'd20000;
    localparam logic [5:0]  MIN_PER_SEC  = 6'd60;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CONV_MUL,
        ST_CONV_DIV,
        ST_START,
        ST_RAMP_SQ,
        ST_RAMP_DIST,
        ST_RAMP_DV,
        ST_RAMP_APPLY,
        ST_SPEED_DIV,
        ST_RESULT
    } ssg_state_t;

    // Request to the shared divider.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } ssg_div_req_t;

endpackage

// ----- rtl/core/ssg_divider.sv -----
// Shared restoring divider, 64 by 64 bits, one quotient bit per cycle.
`timescale 1ns / 1ps
module ssg_divider (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ssg_pkg::ssg_div_req_t req,
    output logic                  done,
    output logic [63:0]           quotient
);
    import ssg_pkg::*;

    logic [63:0] quo_reg, quo_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    // One shift and subtract step a cycle.
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[63]} - {1'b0, den_reg};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[64]) begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = {rem_reg[62:0], quo_reg[63]};
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    // The result pulse follows the last iteration only.
    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy_reg && cnt_reg == 7'd64)
        else $error("divider did not load");
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != 7'd0)
        else $error("divider counter ran out while busy");

endmodule

// ----- rtl/core/stepper_step_generator_accel.sv -----
// Top level of the stepper step generator with trapezoidal ramp.
//
// Channel  | Direction | Handshake          | Payload
// s_       | in        | s_valid / s_ready  | op, reverse, step_count, speed_rpm, accel_rate
// m_       | out       | m_valid / m_ready  | pin levels, busy, counts, speed
// cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Plain ticks and simple commands do not use the divider; a speed update costs one
// pass of the shared divider, a move start two passes and a ramp step three passes.
// Reset is synchronous; the sequencer and motion state return to zero and the
// configuration registers to defaults; scratch and request registers are not reset.
// The block takes no request while one is in work or its result waits.
`timescale 1ns / 1ps
module stepper_step_generator_accel #(
    parameter int PULSE_TICKS      = 1,
    parameter int RAMP_START_SPEED = 50
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic        s_reverse,
    input  logic [31:0] s_step_count,
    input  logic [15:0] s_speed_rpm,
    input  logic [31:0] s_accel_rate,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_step_level,
    output logic        m_dir_level,
    output logic        m_drv_enable,
    output logic        m_busy_res,
    output logic [31:0] m_steps_done,
    output logic [31:0] m_steps_left,
    output logic [31:0] m_speed_now,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import ssg_pkg::*;

    localparam logic [7:0]  PULSE_INIT = PULSE_TICKS[7:0];
    localparam logic [31:0] RAMP_START = RAMP_START_SPEED[31:0];

    ssg_state_t state_reg, state_next;

    // Configuration registers.
    logic [15:0] spr_reg;
    logic [4:0]  ustep_reg;
    logic [23:0] tick_reg;
    logic        invert_reg;

    // Captured request.
    logic [2:0]  op_reg;
    logic        rev_reg;
    logic [31:0] cnt_reg, acc_in_reg;
    logic [15:0] rpm_reg;

    // Motion state.
    logic        running_reg, running_next;
    logic        cont_reg, cont_next;
    logic        ramp_reg, ramp_next;
    logic        enabled_reg, enabled_next;
    logic        dir_reg, dir_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] done_reg, done_next;
    logic [31:0] target_reg, target_next;
    logic [31:0] speed_reg, speed_next;
    logic [31:0] accel_reg, accel_next;
    logic [31:0] phase_reg, phase_next;
    logic [31:0] pstep_reg, pstep_next;
    logic        pulse_reg, pulse_next;
    logic [7:0]  pleft_reg, pleft_next;

    // Scratch registers of the sequencer.
    logic [63:0] prod_reg, prod_next;
    logic [63:0] dist_reg, dist_next;
    logic [31:0] sps_reg, sps_next;
    logic        ramp_cmd_reg, ramp_cmd_next;
    logic        out_valid_reg, out_valid_next;

    ssg_div_req_t div_req;
    logic         div_done;
    logic [63:0]  div_q;

    logic [31:0] dv, rem, new_speed;
    logic [32:0] carry_sum;
    logic        do_start;

    ssg_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quotient(div_q)
    );

    assign s_ready   = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg_ready = (state_reg == ST_IDLE) && !out_valid_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spr_reg    <= SPR_DEFAULT;
            ustep_reg  <= USTEP_DEFAULT;
            tick_reg   <= TICK_DEFAULT;
            invert_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SPR:    spr_reg <= (cfg_data[15:0] != 16'd0) ? cfg_data[15:0] : SPR_DEFAULT;
                REG_USTEP: begin
                    if (cfg_data[4:0] inside {5'd2, 5'd4, 5'd8, 5'd16})
                        ustep_reg <= cfg_data[4:0];
                end
                REG_TICK:   tick_reg <= (cfg_data[23:0] != 24'd0) ? cfg_data[23:0] : TICK_DEFAULT;
                REG_INVERT: invert_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_valid && s_ready) state_next = ST_DECODE;
            ST_DECODE: begin
                case (op_reg)
                    OP_MOVE, OP_RAMP:
                        state_next = (cnt_reg != 0 && rpm_reg != 0) ? ST_CONV_MUL : ST_RESULT;
                    OP_CONT:
                        state_next = (rpm_reg != 0) ? ST_CONV_MUL : ST_RESULT;
                    OP_TICK:
                        state_next = (running_reg && (cont_reg || done_reg < total_reg)
                                      && pstep_reg != 0 && carry_sum[32] && ramp_reg)
                                     ? ST_RAMP_SQ : ST_RESULT;
                    default: state_next = ST_RESULT;
                endcase
            end
            ST_CONV_MUL:  state_next = ST_CONV_DIV;
            ST_CONV_DIV:  if (div_done) state_next = ST_START;
            ST_START:     state_next = do_start ? ST_SPEED_DIV : ST_RESULT;
            ST_RAMP_SQ:   state_next = (speed_reg == 0) ? ST_SPEED_DIV : ST_RAMP_DIST;
            ST_RAMP_DIST: if (div_done || accel_reg == 0) state_next = ST_RAMP_DV;
            ST_RAMP_DV:   if (div_done) state_next = ST_RAMP_APPLY;
            ST_RAMP_APPLY: state_next = ST_SPEED_DIV;
            ST_SPEED_DIV: if (div_done || speed_reg == 0) state_next = ST_RESULT;
            ST_RESULT:    state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    assign carry_sum = {1'b0, phase_reg} + {1'b0, pstep_reg};
    assign rem       = total_reg - done_reg;
    assign dv        = (div_q[31:0] == 32'd0) ? 32'd1 : div_q[31:0];
    assign do_start  = (op_reg != OP_CONT) || (sps_reg != 32'd0);

    // Ramp speed choice, from distance in dist_reg and step in dv.
    always_comb begin
        new_speed = speed_reg;
        if ({32'd0, rem} <= dist_reg)
            new_speed = (speed_reg > dv) ? speed_reg - dv : 32'd1;
        else if (speed_reg < target_reg) begin
            if ({1'b0, speed_reg} + {1'b0, dv} > {1'b0, target_reg})
                new_speed = target_reg;
            else
                new_speed = speed_reg + dv;
        end
    end

    // Datapath and divider requests.
    always_comb begin
        running_next = running_reg;  cont_next   = cont_reg;
        ramp_next    = ramp_reg;     enabled_next = enabled_reg;
        dir_next     = dir_reg;      total_next  = total_reg;
        done_next    = done_reg;     target_next = target_reg;
        speed_next   = speed_reg;    accel_next  = accel_reg;
        phase_next   = phase_reg;    pstep_next  = pstep_reg;
        pulse_next   = pulse_reg;    pleft_next  = pleft_reg;
        prod_next    = prod_reg;     dist_next   = dist_reg;
        sps_next     = sps_reg;      ramp_cmd_next = ramp_cmd_reg;
        out_valid_next = out_valid_reg;
        div_req = '0;
        if (out_valid_reg && m_ready) out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE: prod_next = '0;
            ST_DECODE: begin
                ramp_cmd_next = (op_reg == OP_RAMP) && (acc_in_reg != 0);
                case (op_reg)
                    OP_TICK: begin
                        if (pulse_reg) begin
                            if (pleft_reg > 0 && pleft_reg != 8'd1) pleft_next = pleft_reg - 8'd1;
                            else begin
                                pleft_next = 8'd0;
                                pulse_next = 1'b0;
                            end
                        end
                        if (running_reg) begin
                            if (!cont_reg && done_reg >= total_reg) begin
                                running_next = 1'b0; cont_next = 1'b0;
                                total_next = '0; done_next = '0; target_next = '0;
                                speed_next = '0; pstep_next = '0; phase_next = '0;
                                pulse_next = 1'b0; pleft_next = '0;
                            end else if (pstep_reg != 0) begin
                                phase_next = carry_sum[31:0];
                                if (carry_sum[32]) begin
                                    pulse_next = 1'b1;
                                    pleft_next = PULSE_INIT;
                                    done_next  = done_reg + 32'd1;
                                    if (!cont_reg && done_reg + 32'd1 >= total_reg)
                                        running_next = 1'b0;
                                end
                            end
                        end
                    end
                    OP_STOP: begin
                        running_next = 1'b0; cont_next = 1'b0;
                        total_next = '0; done_next = '0; target_next = '0;
                        speed_next = '0; pstep_next = '0; phase_next = '0;
                        pulse_next = 1'b0; pleft_next = '0;
                    end
                    OP_ENA: enabled_next = 1'b1;
                    OP_DIS: enabled_next = 1'b0;
                    default: ;
                endcase
            end
            ST_CONV_MUL: begin
                prod_next = {32'd0, {16'd0, spr_reg} * {27'd0, ustep_reg}};
            end
            ST_CONV_DIV: begin
                if (prod_reg[63:32] == 32'd0 && prod_reg[31:0] != 32'd0 &&
                    !div_done && !prod_reg[62]) begin
                    // Multiply by rpm once, then hand over to the divider.
                    div_req.start    = 1'b1;
                    div_req.dividend = {32'd0, prod_reg[31:0]} * {48'd0, rpm_reg};
                    div_req.divisor  = {58'd0, MIN_PER_SEC};
                    prod_next        = 64'h4000_0000_0000_0000;
                end
                if (div_done) sps_next = div_q[31:0];
            end
            ST_START: begin
                if (do_start) begin
                    dir_next     = rev_reg ^ invert_reg;
                    enabled_next = 1'b1;
                    cont_next    = (op_reg == OP_CONT);
                    total_next   = (op_reg == OP_CONT) ? 32'hFFFF_FFFF : cnt_reg;
                    done_next    = '0;
                    target_next  = sps_reg;
                    accel_next   = ramp_cmd_reg ? acc_in_reg : 32'd0;
                    ramp_next    = ramp_cmd_reg;
                    phase_next   = '0;
                    speed_next   = (ramp_cmd_reg && sps_reg > RAMP_START) ? RAMP_START : sps_reg;
                    pulse_next   = 1'b0;
                    pleft_next   = '0;
                    running_next = 1'b1;
                end
            end
            ST_RAMP_SQ: begin
                if (speed_reg == 0) speed_next = 32'd1;
                else begin
                    dist_next = '0;
                    if (accel_reg != 0) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {32'd0, speed_reg} * {32'd0, speed_reg};
                        div_req.divisor  = {31'd0, accel_reg, 1'b0};
                    end
                end
            end
            ST_RAMP_DIST: begin
                if (div_done || accel_reg == 0) begin
                    if (div_done) dist_next = div_q;
                    div_req.start    = 1'b1;
                    div_req.dividend = {32'd0, accel_reg};
                    div_req.divisor  = {32'd0, speed_reg};
                end
            end
            ST_RAMP_APPLY: ;
            ST_RAMP_DV: if (div_done) speed_next = new_speed;
            default: ;
        endcase
        // Phase increment from the new speed; started on entry unless the speed is zero.
        if (state_next == ST_SPEED_DIV && state_reg != ST_SPEED_DIV &&
            speed_next != 32'd0) begin
            div_req.start    = 1'b1;
            div_req.dividend = {speed_next, 32'd0};
            div_req.divisor  = {40'd0, tick_reg};
        end
        if (state_reg == ST_SPEED_DIV) begin
            if (speed_reg == 0) pstep_next = '0;
            else if (div_done)
                pstep_next = (div_q[63:32] != 0) ? 32'hFFFF_FFFF : div_q[31:0];
        end
        if (state_reg == ST_RESULT) out_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            running_reg <= 1'b0; cont_reg <= 1'b0; ramp_reg <= 1'b0;
            enabled_reg <= 1'b0; dir_reg <= 1'b0;
            total_reg <= '0; done_reg <= '0; target_reg <= '0;
            speed_reg <= '0; accel_reg <= '0; phase_reg <= '0;
            pstep_reg <= '0; pulse_reg <= 1'b0; pleft_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            running_reg <= running_next; cont_reg <= cont_next; ramp_reg <= ramp_next;
            enabled_reg <= enabled_next; dir_reg <= dir_next;
            total_reg <= total_next; done_reg <= done_next; target_reg <= target_next;
            speed_reg <= speed_next; accel_reg <= accel_next; phase_reg <= phase_next;
            pstep_reg <= pstep_next; pulse_reg <= pulse_next; pleft_reg <= pleft_next;
            out_valid_reg <= out_valid_next;
        end
        prod_reg <= prod_next; dist_reg <= dist_next; sps_reg <= sps_next;
        ramp_cmd_reg <= ramp_cmd_next;
        if (s_valid && s_ready) begin
            op_reg <= s_op; rev_reg <= s_reverse; cnt_reg <= s_step_count;
            rpm_reg <= s_speed_rpm; acc_in_reg <= s_accel_rate;
        end
    end

    // Result outputs come straight from the state registers.
    assign m_valid          = out_valid_reg;
    assign m_step_level     = pulse_reg;
    assign m_dir_level      = dir_reg;
    assign m_drv_enable     = enabled_reg;
    assign m_busy_res       = running_reg;
    assign m_steps_done     = done_reg;
    assign m_steps_left     = (done_reg >= total_reg) ? 32'd0 : total_reg - done_reg;
    assign m_speed_now      = speed_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> state_reg == ST_IDLE)
        else $error("result shown while work in progress");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESULT) |=> m_valid)
        else $error("finished request gave no result");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == ST_DECODE)
        else $error("accepted request not decoded");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cont_reg |-> total_reg == 32'hFFFF_FFFF)
        else $error("continuous run without full count");

endmodule
